FILE: src/mmf_pkg.sv
`timescale 1ns / 1ps
package mmf_pkg;

  // Default number of stored elements.
  localparam int unsigned DefCapacity = 32;

  // Depth of the queues on the input and result sides.
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    KIND_COUNT = 2'd0,
    KIND_FREQ  = 2'd1,
    KIND_MODE  = 2'd2
  } kind_e;

  typedef struct packed {
    logic               last;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] value;
    logic               fin;
  } res_t;

endpackage

FILE: src/multiset_mode_finder.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake      Beat contents
// input     in         push / full    value_i, last_i
// result    out        pop / empty    kind_o, result_value_o, final_res_o
//
// An item is written directly into an empty store and dropped at a full one; otherwise
// each stored element larger than it moves up one place. A last item then starts a pass
// that finds the longest run; only a run of two or more adds a counting pass and, after
// the headers, an emitting pass. Each pass opens in a start state, then reads each stored
// element in turn. rst_ni clears the control state and both queues; the store is never
// read above the fill count. A full result queue stalls the engine, losing no beat.
module multiset_mode_finder import mmf_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] value_i,
  input  logic               last_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind_o,
  output logic signed [31:0] result_value_o,
  output logic               final_res_o
);

  // Front side: incoming beats wait in a short queue until the engine is free.
  item_t in_item, eng_item;
  logic  in_empty, item_take;

  // Back side: results from the engine wait in a second queue for the consumer.
  res_t  eng_res, out_res;
  logic  res_push, res_full;

  assign in_item = '{last: last_i, value: value_i};

  mmf_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(QueueDepth)
  ) u_in_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (in_item),
    .full_o (full),
    .pop_i  (item_take),
    .data_o (eng_item),
    .empty_o(in_empty)
  );

  // The engine does the sorted insert and up to three scans over the store.
  mmf_engine #(
    .CAPACITY(CAPACITY)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_avail_i(~in_empty),
    .item_i      (eng_item),
    .item_take_o (item_take),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (eng_res)
  );

  mmf_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(QueueDepth)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (eng_res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_res),
    .empty_o(empty)
  );

  assign kind_o         = out_res.kind;
  assign result_value_o = out_res.value;
  assign final_res_o    = out_res.fin;

endmodule

FILE: src/mmf_ram.sv
`timescale 1ns / 1ps
module mmf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/mmf_fifo.sv
`timescale 1ns / 1ps
module mmf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: src/mmf_engine.sv
`timescale 1ns / 1ps
module mmf_engine import mmf_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_avail_i,
  input  item_t item_i,
  output logic  item_take_o,
  input  logic  res_full_i,
  output logic  res_push_o,
  output res_t  res_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_INS_CMP = 7'b0000010,
    ST_INS_PUT = 7'b0000100,
    ST_FIRST   = 7'b0001000,
    ST_SCAN    = 7'b0010000,
    ST_HDR_CNT = 7'b0100000,
    ST_HDR_FRQ = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    P_BEST  = 2'd0,
    P_COUNT = 2'd1,
    P_EMIT  = 2'd2
  } pass_e;

  state_e             state_q, state_d;
  pass_e              pass_q, pass_d;
  logic [CW-1:0]      fill_q, fill_d;
  logic [CW-1:0]      run_q, run_d, best_q, best_d, mc_q, mc_d, emit_q, emit_d;
  logic [AW-1:0]      pos_q, pos_d, el_q, el_d;
  logic signed [31:0] v_q, v_d, prev_q, prev_d;
  logic               last_q, last_d;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic signed [31:0] wdata, rdata;

  logic [CW-1:0]      last_idx, run_nx, best_nx, freq;
  logic               eq, hit, at_end, fill_full;

  mmf_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign last_idx  = fill_q - CW'(1);
  assign fill_full = (fill_q == CW'(CAPACITY));
  assign at_end    = (CW'(el_q) == last_idx);
  assign eq        = (el_q != '0) && (rdata == prev_q);
  assign run_nx    = eq ? run_q + CW'(1) : CW'(1);
  assign hit       = (run_nx == best_q);
  assign best_nx   = (run_nx > best_q) ? run_nx : best_q;
  assign freq      = (best_q < CW'(1)) ? CW'(1) : best_q;

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    fill_d      = fill_q;
    run_d       = run_q;
    best_d      = best_q;
    mc_d        = mc_q;
    emit_d      = emit_q;
    pos_d       = pos_q;
    el_d        = el_q;
    v_d         = v_q;
    prev_d      = prev_q;
    last_d      = last_q;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = v_q;
    raddr       = el_q;
    item_take_o = 1'b0;
    res_push_o  = 1'b0;
    res_o       = '{kind: KIND_COUNT, value: '0, fin: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (item_avail_i) begin
          item_take_o = 1'b1;
          v_d         = item_i.value;
          last_d      = item_i.last;
          pass_d      = P_BEST;
          if (fill_full) begin
            state_d = item_i.last ? ST_FIRST : ST_IDLE;
          end else if (fill_q == '0) begin
            we      = 1'b1;
            waddr   = '0;
            wdata   = item_i.value;
            fill_d  = fill_q + CW'(1);
            state_d = item_i.last ? ST_FIRST : ST_IDLE;
          end else begin
            pos_d   = fill_q[AW-1:0];
            raddr   = last_idx[AW-1:0];
            state_d = ST_INS_CMP;
          end
        end
      end

      ST_INS_CMP: begin
        we = 1'b1;
        if (rdata > v_q) begin
          // Larger neighbour moves up one place; keep walking down.
          wdata = rdata;
          pos_d = pos_q - AW'(1);
          if (pos_q == AW'(1)) begin
            state_d = ST_INS_PUT;
          end else begin
            raddr = pos_q - AW'(2);
          end
        end else begin
          fill_d  = fill_q + CW'(1);
          state_d = last_q ? ST_FIRST : ST_IDLE;
        end
      end

      ST_INS_PUT: begin
        we      = 1'b1;
        fill_d  = fill_q + CW'(1);
        state_d = last_q ? ST_FIRST : ST_IDLE;
      end

      ST_FIRST: begin
        raddr   = '0;
        el_d    = '0;
        run_d   = '0;
        state_d = ST_SCAN;
        unique case (pass_q)
          P_BEST:  best_d = '0;
          P_COUNT: mc_d   = '0;
          P_EMIT:  emit_d = '0;
          default: best_d = '0;
        endcase
        if (fill_q == '0) begin
          best_d  = '0;
          mc_d    = '0;
          state_d = ST_HDR_CNT;
        end
      end

      ST_SCAN: begin
        if (pass_q == P_EMIT && hit && res_full_i) begin
          raddr = el_q;
        end else begin
          run_d  = run_nx;
          prev_d = rdata;
          unique case (pass_q)
            P_BEST: best_d = best_nx;
            P_COUNT: begin
              if (hit) begin
                mc_d = mc_q + CW'(1);
              end
            end
            P_EMIT: begin
              if (hit) begin
                res_push_o = 1'b1;
                res_o      = '{kind: KIND_MODE, value: rdata,
                               fin: (emit_q + CW'(1) == mc_q)};
                emit_d     = emit_q + CW'(1);
              end
            end
            default: best_d = best_q;
          endcase
          if (at_end) begin
            unique case (pass_q)
              P_BEST: begin
                if (best_nx >= CW'(2)) begin
                  pass_d  = P_COUNT;
                  state_d = ST_FIRST;
                end else begin
                  mc_d    = '0;
                  state_d = ST_HDR_CNT;
                end
              end
              P_COUNT: state_d = ST_HDR_CNT;
              P_EMIT: begin
                fill_d  = '0;
                state_d = ST_IDLE;
              end
              default: state_d = ST_IDLE;
            endcase
          end else begin
            el_d  = el_q + AW'(1);
            raddr = el_q + AW'(1);
          end
        end
      end

      ST_HDR_CNT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o      = '{kind: KIND_COUNT, value: 32'(mc_q), fin: 1'b0};
          state_d    = ST_HDR_FRQ;
        end
      end

      ST_HDR_FRQ: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o      = '{kind: KIND_FREQ, value: 32'(freq), fin: (mc_q == '0)};
          if (mc_q == '0) begin
            fill_d  = '0;
            state_d = ST_IDLE;
          end else begin
            pass_d  = P_EMIT;
            state_d = ST_FIRST;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= P_BEST;
      fill_q  <= '0;
      run_q   <= '0;
      best_q  <= '0;
      mc_q    <= '0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      fill_q  <= fill_d;
      run_q   <= run_d;
      best_q  <= best_d;
      mc_q    <= mc_d;
      emit_q  <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    el_q   <= el_d;
    v_q    <= v_d;
    prev_q <= prev_d;
    last_q <= last_d;
  end

endmodule

FILE: src/mmf_checker.sv
`timescale 1ns / 1ps
module mmf_checker import mmf_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic [1:0]         kind_o,
  input logic signed [31:0] result_value_o,
  input logic               final_res_o
);

  // A waiting result beat holds until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(kind_o) && $stable(result_value_o)
                          && $stable(final_res_o)))
    else $error("result beat changed while stalled");

  // The mode count never ends a run and is at most half the capacity.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_COUNT) |->
      (!final_res_o && $unsigned(result_value_o) <= 32'(CAPACITY / 2)))
    else $error("bad mode count beat");

  // The frequency lies between one and the capacity.
  a_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_FREQ) |->
      ($unsigned(result_value_o) >= 32'd1
       && $unsigned(result_value_o) <= 32'(CAPACITY)))
    else $error("bad frequency beat");

  // Only the three defined result kinds appear.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (kind_o == KIND_COUNT || kind_o == KIND_FREQ || kind_o == KIND_MODE))
    else $error("undefined result kind");

endmodule

bind multiset_mode_finder mmf_checker #(.CAPACITY(CAPACITY)) u_mmf_checker (.*);
